[hdl/best_shift_match_count_core_macros.svh]
// Assertion helpers for the best shift match count core.
`ifndef BEST_SHIFT_MATCH_COUNT_CORE_MACROS_SVH
`define BEST_SHIFT_MATCH_COUNT_CORE_MACROS_SVH

// Clocked assertion, quiet while reset is held.
`define BSMC_ASSERT_CLK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("bsmc assertion failed");

// Clocked assertion that also holds during reset.
`define BSMC_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("bsmc assertion failed");

`endif

[hdl/bsmc_pkg.sv]
package bsmc_pkg;

	localparam int CH_W  = 8;
	localparam int OUT_W = 8;
	localparam int OP_W  = 2;

	localparam logic [OP_W-1:0] OP_APPEND_A = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND_B = 2'd1;
	localparam logic [OP_W-1:0] OP_COMPUTE  = 2'd2;

	localparam int ST_W = 2;
	localparam logic [ST_W-1:0] ST_IDLE  = 2'd0;
	localparam logic [ST_W-1:0] ST_WALK  = 2'd1;
	localparam logic [ST_W-1:0] ST_DRAIN = 2'd2;
	localparam logic [ST_W-1:0] ST_FIN   = 2'd3;

	typedef logic [CH_W-1:0] char_t;

endpackage

[hdl/bsmc_store.sv]
// Character store: one write port, one read port, registered read data.
module bsmc_store import bsmc_pkg::*; #(
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  char_t                    wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output char_t                    rdata
);

	char_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/best_shift_match_count_core.sv]
// Best shift match count core.
// Input channel (in_valid / in_stall, opcode, ch): opcode APPEND_A / APPEND_B
// appends ch to the first / second string, one beat per cycle unless stalled;
// a character past MAX_LEN is dropped and sets the overflow flag. Opcode
// COMPUTE starts the search; opcode 3 is taken and ignored.
// Output channel (out_valid / out_stall, best_count, overflow): one beat per
// COMPUTE, the largest count of equal characters over all relative shifts,
// saturated at 255. The pair's lengths and overflow flag clear afterwards.
// Search: a COMPUTE on strings of lengths n1, n2 walks every diagonal of
// the n2 x n1 position grid, one position pair per cycle through the two
// store read ports, then drains the compare stage and out_valid rises; an
// empty string skips the walk. in_stall is high meanwhile.
// Appends are taken while a result waits.
// Reset: lengths, flag, FSM and output valid clear; store contents are
// left as is, only entries written since the last COMPUTE are read.
// A stalled result holds in the output register; a finished search waits
// in its final state until the output register frees up.
module best_shift_match_count_core import bsmc_pkg::*; #(
	parameter int MAX_LEN = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [OP_W-1:0]  opcode,
	input  logic [CH_W-1:0]  ch,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [OUT_W-1:0] best_count,
	output logic             overflow
);

	localparam int AW = $clog2(MAX_LEN);      // store index
	localparam int LW = $clog2(MAX_LEN + 1);  // length / count

	logic [ST_W-1:0] state_q;
	logic [LW-1:0]   len_a_q, len_b_q;
	logic            drop_q;

	// diagonal start and current read position (i: second, j: first)
	logic [AW-1:0]   si_q, sj_q, ri_q, rj_q;
	logic            first_q;

	logic            vld_s1, first_s1, done_s1;
	logic [LW-1:0]   cnt_q, best_q;

	logic            out_valid_q, ovf_q;
	logic [OUT_W-1:0] best_count_q;

	char_t           rd_a, rd_b;

	logic            acc, ld_a, ld_b, full_a, full_b;
	logic            diag_end, all_end, out_free;
	logic [LW-1:0]   cnt_new;

	assign in_stall = (state_q != ST_IDLE);
	assign acc      = in_valid && !in_stall;
	assign full_a   = (len_a_q == LW'(MAX_LEN));
	assign full_b   = (len_b_q == LW'(MAX_LEN));
	assign ld_a     = acc && (opcode == OP_APPEND_A) && !full_a;
	assign ld_b     = acc && (opcode == OP_APPEND_B) && !full_b;

	bsmc_store #(.DEPTH(MAX_LEN)) u_store_a (
		.clk   (clk),
		.we    (ld_a),
		.waddr (len_a_q[AW-1:0]),
		.wdata (ch),
		.raddr (rj_q),
		.rdata (rd_a)
	);

	bsmc_store #(.DEPTH(MAX_LEN)) u_store_b (
		.clk   (clk),
		.we    (ld_b),
		.waddr (len_b_q[AW-1:0]),
		.wdata (ch),
		.raddr (ri_q),
		.rdata (rd_b)
	);

	// end of the current diagonal, and of the last one (i = 0, j = n1-1)
	assign diag_end = (LW'(ri_q) == len_b_q - LW'(1)) || (LW'(rj_q) == len_a_q - LW'(1));
	assign all_end  = diag_end && (si_q == '0) && (LW'(sj_q) == len_a_q - LW'(1));

	// running count on the diagonal in flight
	assign cnt_new  = (first_s1 ? '0 : cnt_q) + LW'(rd_a == rd_b);
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_a_q     <= '0;
			len_b_q     <= '0;
			drop_q      <= 1'b0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_WALK);
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc && opcode == OP_APPEND_A) begin
						if (full_a) begin
							drop_q <= 1'b1;
						end else begin
							len_a_q <= len_a_q + LW'(1);
						end
					end
					if (acc && opcode == OP_APPEND_B) begin
						if (full_b) begin
							drop_q <= 1'b1;
						end else begin
							len_b_q <= len_b_q + LW'(1);
						end
					end
					if (acc && opcode == OP_COMPUTE) begin
						if (len_a_q == '0 || len_b_q == '0) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (all_end) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (vld_s1 && done_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						len_a_q     <= '0;
						len_b_q     <= '0;
						drop_q      <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// walk addresses and the compare stage: payload, no reset
	always_ff @(posedge clk) begin
		first_s1 <= first_q;
		done_s1  <= all_end;
		if (state_q == ST_IDLE) begin
			// first diagonal: last char of second against first char of first
			si_q    <= AW'(len_b_q - LW'(1));
			sj_q    <= '0;
			ri_q    <= AW'(len_b_q - LW'(1));
			rj_q    <= '0;
			first_q <= 1'b1;
			best_q  <= '0;
		end else if (state_q == ST_WALK) begin
			if (diag_end) begin
				first_q <= 1'b1;
				if (si_q != '0) begin
					si_q <= si_q - AW'(1);
					ri_q <= si_q - AW'(1);
					rj_q <= '0;
				end else begin
					sj_q <= sj_q + AW'(1);
					ri_q <= '0;
					rj_q <= sj_q + AW'(1);
				end
			end else begin
				first_q <= 1'b0;
				ri_q    <= ri_q + AW'(1);
				rj_q    <= rj_q + AW'(1);
			end
		end
		if (vld_s1) begin
			cnt_q <= cnt_new;
			if (cnt_new > best_q) begin
				best_q <= cnt_new;
			end
		end
		if (state_q == ST_FIN && out_free) begin
			best_count_q <= (32'(best_q) > 32'd255) ? OUT_W'(255) : OUT_W'(best_q);
			ovf_q        <= drop_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign best_count = best_count_q;
	assign overflow   = ovf_q;

endmodule

[hdl/bsmc_checker.sv]
`include "best_shift_match_count_core_macros.svh"

module bsmc_checker import bsmc_pkg::*; #(
	parameter int MAX_LEN = 128
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic [OP_W-1:0]  opcode,
	input logic             out_valid,
	input logic             out_stall,
	input logic [OUT_W-1:0] best_count
);

	`BSMC_ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid)
	`BSMC_ASSERT_CLK(a_busy_after_compute,
		in_valid && !in_stall && opcode == OP_COMPUTE |=> in_stall)
	`BSMC_ASSERT_CLK(a_no_result_from_append,
		in_valid && !in_stall && opcode != OP_COMPUTE && !out_valid |=> !out_valid)
	`BSMC_ASSERT_CLK(a_count_bound,
		out_valid |-> (MAX_LEN > 255) || (32'(best_count) <= MAX_LEN))
	`BSMC_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !out_valid)

endmodule

bind best_shift_match_count_core bsmc_checker #(.MAX_LEN(MAX_LEN)) u_bsmc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.opcode     (opcode),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.best_count (best_count)
);
